[design/xpfec_pkg.sv]
package xpfec_pkg;

    // field widths fixed by the packet format
    localparam int SEQ_W  = 32;
    localparam int WORD_W = 64;

    // default frame length in payload words
    localparam int FRAME_WORDS_DEFAULT = 20;

    // result kind codes
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_PARITY = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [WORD_W-1:0] payload_word;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  packet_seq;
        logic [WORD_W-1:0] word_out;
        logic              end_of_packet;
        logic              end_of_run;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREAD,
        ST_PARITY
    } state_t;

endpackage

[design/xpfec_ram.sv]
module xpfec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 20,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/xor_pair_parity_fec_encoder.sv]
// xor pair parity fec encoder: frames of FRAME_WORDS 64-bit words come in one word per
// transfer, each tagged with the frame seq. every word goes straight out as a data result.
// a frame whose seq is odd and one past the stored frame's seq is xored word by word into
// the pair buffer, and after its last data word the block sends a parity packet of
// FRAME_WORDS words carrying the first frame's seq; any other frame overwrites the buffer
// and becomes the stored frame. each input word is accepted in the idle state while the
// pair buffer memory reads its entry, then the update state writes back the merged word and
// loads the result register, waiting while the output register is full. a parity burst
// primes the memory read, then sends one parity word per cycle while the output register
// can take it; the single pair buffer memory has a registered read. a result waiting in the
// output register does not keep the next input from being taken.
module xor_pair_parity_fec_encoder #(
    parameter int FRAME_WORDS = xpfec_pkg::FRAME_WORDS_DEFAULT,
    localparam int IdxW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  xpfec_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_ready,
    output xpfec_pkg::result_t result
);

    // fsm
    xpfec_pkg::state_t state_reg, state_next;

    // frame tracking
    logic [IdxW-1:0] word_count_reg, word_count_next;
    logic            pairs_reg, pairs_next;
    logic            stored_valid_reg, stored_valid_next;
    logic [xpfec_pkg::SEQ_W-1:0] stored_seq_reg, stored_seq_next;

    // accepted word, held for the read-modify-write
    logic [xpfec_pkg::SEQ_W-1:0]  seq_reg, seq_next;
    logic [xpfec_pkg::WORD_W-1:0] word_reg, word_next;

    // parity burst position
    logic [IdxW-1:0] parity_idx_reg, parity_idx_next;

    // output register
    logic               result_valid_reg, result_valid_next;
    xpfec_pkg::result_t result_reg, result_next;

    // pair buffer memory port
    logic                         ram_we;
    logic [IdxW-1:0]              ram_waddr;
    logic [xpfec_pkg::WORD_W-1:0] ram_wdata;
    logic [IdxW-1:0]              ram_raddr;
    logic [xpfec_pkg::WORD_W-1:0] ram_rdata;

    logic item_accept;
    logic slot_free;
    logic last_word;
    logic parity_last;
    logic pair_hit;

    assign item_accept = item_valid && item_ready;
    // output register is empty or is being emptied this cycle
    assign slot_free   = !result_valid_reg || result_ready;
    assign last_word   = (word_count_reg == IdxW'(FRAME_WORDS - 1));
    assign parity_last = (parity_idx_reg == IdxW'(FRAME_WORDS - 1));
    // frame pairs with the stored one: consecutive seq, odd second frame
    assign pair_hit    = stored_valid_reg
                         && (item.seq == (stored_seq_reg + xpfec_pkg::SEQ_W'(1)))
                         && item.seq[0];

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    xpfec_ram #(
        .WIDTH (xpfec_pkg::WORD_W),
        .DEPTH (FRAME_WORDS)
    ) u_pair_buffer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xpfec_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = xpfec_pkg::ST_UPDATE;
                end
            end
            xpfec_pkg::ST_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next = (last_word && pairs_reg) ? xpfec_pkg::ST_PREAD
                                                          : xpfec_pkg::ST_IDLE;
                end
            end
            xpfec_pkg::ST_PREAD:
            begin
                state_next = xpfec_pkg::ST_PARITY;
            end
            xpfec_pkg::ST_PARITY:
            begin
                if (slot_free && parity_last)
                begin
                    state_next = xpfec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xpfec_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        item_ready        = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = word_count_reg;
        // merge into the buffer when pairing, otherwise overwrite
        ram_wdata         = pairs_reg ? (ram_rdata ^ word_reg) : word_reg;
        // idle reads the entry of the next word so it is ready on accept
        ram_raddr         = word_count_reg;
        word_count_next   = word_count_reg;
        pairs_next        = pairs_reg;
        stored_valid_next = stored_valid_reg;
        stored_seq_next   = stored_seq_reg;
        seq_next          = seq_reg;
        word_next         = word_reg;
        parity_idx_next   = parity_idx_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;

        unique case (state_reg)
            xpfec_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_accept)
                begin
                    seq_next  = item.seq;
                    word_next = item.payload_word;
                    // pairing is settled on the first word of a frame
                    if (word_count_reg == '0)
                    begin
                        pairs_next = pair_hit;
                    end
                end
            end
            xpfec_pkg::ST_UPDATE:
            begin
                if (slot_free)
                begin
                    ram_we                    = 1'b1;
                    result_valid_next         = 1'b1;
                    result_next.kind          = xpfec_pkg::KIND_DATA;
                    result_next.packet_seq    = seq_reg;
                    result_next.word_out      = word_reg;
                    result_next.end_of_packet = last_word;
                    result_next.end_of_run    = !(last_word && pairs_reg);
                    if (last_word)
                    begin
                        word_count_next = '0;
                        if (pairs_reg)
                        begin
                            stored_valid_next = 1'b0;
                            pairs_next        = 1'b0;
                        end
                        else
                        begin
                            stored_seq_next   = seq_reg;
                            stored_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        word_count_next = word_count_reg + IdxW'(1);
                    end
                end
            end
            xpfec_pkg::ST_PREAD:
            begin
                // prime the read of the first parity word
                ram_raddr       = '0;
                parity_idx_next = '0;
            end
            xpfec_pkg::ST_PARITY:
            begin
                ram_raddr = parity_idx_reg;
                if (slot_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.kind          = xpfec_pkg::KIND_PARITY;
                    result_next.packet_seq    = stored_seq_reg;
                    result_next.word_out      = ram_rdata;
                    result_next.end_of_packet = parity_last;
                    result_next.end_of_run    = parity_last;
                    if (!parity_last)
                    begin
                        // read ahead so the next word is there next cycle
                        parity_idx_next = parity_idx_reg + IdxW'(1);
                        ram_raddr       = parity_idx_reg + IdxW'(1);
                    end
                end
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= xpfec_pkg::ST_IDLE;
            word_count_reg   <= '0;
            pairs_reg        <= 1'b0;
            stored_valid_reg <= 1'b0;
            stored_seq_reg   <= '0;
            parity_idx_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            word_count_reg   <= word_count_next;
            pairs_reg        <= pairs_next;
            stored_valid_reg <= stored_valid_next;
            stored_seq_reg   <= stored_seq_next;
            parity_idx_reg   <= parity_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        seq_reg    <= seq_next;
        word_reg   <= word_next;
        result_reg <= result_next;
    end

    // an accepted word is always followed by its buffer update
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> (state_reg == xpfec_pkg::ST_UPDATE))
        else $error("accepted word not followed by buffer update");

    // word position never leaves the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        word_count_reg <= IdxW'(FRAME_WORDS - 1))
        else $error("word counter out of range");

    // the stored frame is consumed once its parity burst starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xpfec_pkg::ST_PREAD) |-> (!stored_valid_reg && !pairs_reg))
        else $error("pairing state not cleared before parity burst");

    // the last parity word ends the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xpfec_pkg::ST_PARITY && slot_free && parity_last)
        |=> (state_reg == xpfec_pkg::ST_IDLE && result_valid_reg
             && result_reg.end_of_run))
        else $error("parity burst did not end on its last word");

    // no buffer write outside the read-modify-write step
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == xpfec_pkg::ST_UPDATE && slot_free))
        else $error("pair buffer written outside update");

endmodule

[dv/testbench.sv]
module testbench;
    import xpfec_pkg::*;

    // frame length of the instance, taken from the package default
    localparam int FRAME_LEN = FRAME_WORDS_DEFAULT;
    // generous ceiling for a run of a few hundred words and parity bursts
    localparam int CYCLE_LIMIT = 100000;
    // settle time after the last result: longer than one parity burst
    localparam int DRAIN_CYCLES = 2 * FRAME_LEN + 20;
    // long receiver hold-off, enough to back the block up into its input
    localparam int LONG_HOLD = 400;

    // payload fill styles for a frame
    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME
    } fill_t;

    // receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } rx_mode_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    xor_pair_parity_fec_encoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // encoder shadow state: pair buffer, stored frame and position in the frame
    logic [WORD_W-1:0] parity_acc [FRAME_LEN];
    logic              stored_ok         = 1'b0;
    logic [SEQ_W-1:0]  stored_frame_seq  = '0;
    int                word_pos          = 0;
    logic              frame_is_partner  = 1'b0;

    // results still owed by the block, oldest first
    result_t expected_words [$];
    result_t head_word;

    // sender and receiver controls
    int       burst_left   = 0;
    bit       gaps_on      = 1'b1;
    rx_mode_t rx_mode      = RX_ALWAYS;
    int       rx_hold_left = 0;
    int       rx_phase     = 0;

    // bookkeeping
    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int parity_seen     = 0;
    int input_stalls    = 0;
    int cycle_count     = 0;

    initial
    begin
        for (int i = 0; i < FRAME_LEN; i++)
            parity_acc[i] = '0;
    end

    // work out every result that one accepted word causes
    task automatic predict_encoder(input item_t it);
        logic    last_word;
        result_t r;
        int      i;
        // pairing is decided once, from the seq of the frame's first word
        if (word_pos == 0)
            frame_is_partner = stored_ok && (it.seq == SEQ_W'(stored_frame_seq + 1))
                               && it.seq[0];
        if (frame_is_partner)
            parity_acc[word_pos] = parity_acc[word_pos] ^ it.payload_word;
        else
            parity_acc[word_pos] = it.payload_word;
        last_word = (word_pos == FRAME_LEN - 1);

        // the data word always goes straight out
        r.kind          = KIND_DATA;
        r.packet_seq    = it.seq;
        r.word_out      = it.payload_word;
        r.end_of_packet = last_word;
        r.end_of_run    = !(last_word && frame_is_partner);
        expected_words.push_back(r);

        if (last_word)
        begin
            if (frame_is_partner)
            begin
                // parity packet carries the first frame's seq
                for (i = 0; i < FRAME_LEN; i++)
                begin
                    r.kind          = KIND_PARITY;
                    r.packet_seq    = stored_frame_seq;
                    r.word_out      = parity_acc[i];
                    r.end_of_packet = (i == FRAME_LEN - 1);
                    r.end_of_run    = (i == FRAME_LEN - 1);
                    expected_words.push_back(r);
                end
                stored_ok        = 1'b0;
                frame_is_partner = 1'b0;
            end
            else
            begin
                // a lone frame becomes the stored one, tagged with its last word's seq
                stored_frame_seq = it.seq;
                stored_ok        = 1'b1;
            end
            word_pos = 0;
        end
        else
        begin
            word_pos++;
        end
    endtask

    // one word transfer; called and returns at a falling edge
    task automatic send_word(input logic [SEQ_W-1:0] s, input logic [WORD_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap        = gaps_on ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= '{seq: s, payload_word: w};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_encoder(item);
        words_sent++;
        @(negedge clk);
    endtask

    // one whole frame; the seq of the first word may differ from the rest
    task automatic send_frame(input logic [SEQ_W-1:0] head_seq,
                              input logic [SEQ_W-1:0] tail_seq,
                              input fill_t fill, input int ofs);
        logic [WORD_W-1:0] w;
        int                i;
        for (i = 0; i < FRAME_LEN; i++)
        begin
            if (fill == FILL_EXTREME)
            begin
                case ((i + ofs) % 5)
                    0:       w = '0;
                    1:       w = '1;
                    2:       w = {32{2'b10}};
                    3:       w = {32{2'b01}};
                    default: w = WORD_W'(1) << (i * 3 + ofs);
                endcase
            end
            else
            begin
                w = {$urandom, $urandom};
            end
            send_word((i == 0) ? head_seq : tail_seq, w);
        end
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drain();
        item_valid <= 1'b0;
        @(negedge clk);
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    // pair at the top of the seq range, payloads at their extremes, no idling anywhere
    task automatic test_pair_extremes();
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        send_frame(32'hFFFF_FFFE, 32'hFFFF_FFFE, FILL_EXTREME, 0);
        send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, FILL_EXTREME, 2);
        wait_drain();
    endtask

    // seq zero, seq moving mid-frame, flag cleared after parity, even follower
    task automatic test_pairing_rules();
        gaps_on = 1'b1;
        rx_mode = RX_MOSTLY;
        // seq zero is stored
        send_frame(32'h0000_0000, 32'h0000_0000, FILL_RANDOM, 0);
        // odd follower pairs on its first word even though later words carry another seq
        send_frame(32'h0000_0001, 32'h8000_0000, FILL_RANDOM, 0);
        // same follower again: the pairing flag was cleared by the parity packet
        send_frame(32'h0000_0001, 32'h0000_0001, FILL_RANDOM, 0);
        // even seq one past the stored one never pairs; stores its last word's seq
        send_frame(32'h0000_0002, 32'h0000_0013, FILL_EXTREME, 1);
        wait_drain();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering a pair
    task automatic test_output_backpressure();
        logic [SEQ_W-1:0] s;
        s       = $urandom;
        s[0]    = 1'b0;
        gaps_on = 1'b1;
        rx_mode = RX_COIN;
        @(posedge clk);
        rx_hold_left = LONG_HOLD;
        @(negedge clk);
        send_frame(s, s, FILL_RANDOM, 0);
        send_frame(SEQ_W'(s + 1), SEQ_W'(s + 1), FILL_RANDOM, 0);
        wait_drain();
    endtask

    // mostly well-formed pairs with random content, some lone and broken frames
    task automatic test_random_traffic();
        int               frames;
        int               pick;
        logic [SEQ_W-1:0] s;
        frames = 0;
        while (frames < 5)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            gaps_on = ($urandom_range(0, 3) != 0);
            s       = $urandom;
            pick    = $urandom_range(0, 9);
            if (pick < 6)
            begin
                s[0] = 1'b0;
                send_frame(s, s, FILL_RANDOM, 0);
                send_frame(SEQ_W'(s + 1), SEQ_W'(s + 1), FILL_RANDOM, 0);
                frames += 2;
            end
            else if (pick == 6)
            begin
                send_frame(s, s, FILL_RANDOM, 0);
                frames++;
            end
            else if (pick == 7)
            begin
                // follower skips two seqs
                s[0] = 1'b0;
                send_frame(s, s, FILL_RANDOM, 0);
                send_frame(SEQ_W'(s + 3), SEQ_W'(s + 3), FILL_RANDOM, 0);
                frames += 2;
            end
            else if (pick == 8)
            begin
                send_frame(s, $urandom, FILL_RANDOM, 0);
                frames++;
            end
            else
            begin
                // odd frame followed by an even one
                s[0] = 1'b1;
                send_frame(s, s, FILL_RANDOM, 0);
                send_frame(SEQ_W'(s + 1), SEQ_W'(s + 1), FILL_RANDOM, 0);
                frames += 2;
            end
            if ($urandom_range(0, 2) == 0)
                wait_drain();
        end
    endtask

    // receiver: long hold-off when asked, otherwise its current stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_left > 0)
            begin
                result_ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:   result_ready <= 1'b1;
                    RX_COIN:     result_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:   result_ready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        rx_phase++;
                        result_ready <= ((rx_phase % 5) > 1);
                    end
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s expected %h got %h", name, want, got);
            errors++;
        end
    endfunction

    // result checker: every result transfer against the oldest owed result
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result with nothing owed: kind %0d seq %h word %h",
                       result.kind, result.packet_seq, result.word_out);
                errors++;
            end
            else
            begin
                head_word = expected_words.pop_front();
                check_field("kind", head_word.kind, result.kind);
                check_field("packet_seq", head_word.packet_seq, result.packet_seq);
                check_field("word_out", head_word.word_out, result.word_out);
                check_field("end_of_packet", head_word.end_of_packet, result.end_of_packet);
                check_field("end_of_run", head_word.end_of_run, result.end_of_run);
                results_checked++;
                if (head_word.kind == KIND_PARITY && head_word.end_of_packet)
                    parity_seen++;
            end
        end
    end

    // cycle counter with timeout, and input stall count
    always @(posedge clk)
    begin
        cycle_count++;
        if (item_valid && !item_ready)
            input_stalls++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_pair_extremes();
        test_pairing_rules();
        test_output_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d word transfers and %0d checked results, %0d parity packets",
                 words_sent, results_checked, parity_seen);
        $display("input offered but not taken for %0d cycles", input_stalls);
        if (errors == 0 && expected_words.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[files.f]
design/xpfec_pkg.sv
design/xpfec_ram.sv
design/xor_pair_parity_fec_encoder.sv
dv/testbench.sv
